@@ design/stlb_pkg.sv @@
// ----------------------------------------------------------------------------
// stlb_pkg
// Shared constants, types and helpers of the set-associative TLB.
// ----------------------------------------------------------------------------
`default_nettype none

package stlb_pkg;

	// Address geometry
	localparam int VA_W  = 48;
	localparam int PPN_W = 40;
	localparam int OFF_W = 12;
	localparam int PA_W  = PPN_W + OFF_W;
	localparam int OP_W  = 2;

	// Stream packing: input tdata holds va then ppn, output tdata holds pa
	localparam int S_TDATA_W = ((VA_W + PPN_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((PA_W + 7) / 8) * 8;

	// Default organization
	localparam int DEF_WAYS           = 8;
	localparam int DEF_SET_INDEX_BITS = 4;

	// Victim LFSR (Galois, shift right)
	localparam int                LFSR_W    = 16;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	// Operation codes
	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_LOOKUP = 2'd0;
	localparam op_t OP_FILL   = 2'd1;
	localparam op_t OP_FLUSH  = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // capture the request and start the set read
		logic commit;  // update state and capture the result
	} stlb_cmd_t;

	// Advance the victim LFSR by one step
	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] n;
		n = v >> 1;
		if (v[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

@@ design/stlb_ram.sv @@
// ----------------------------------------------------------------------------
// stlb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ design/stlb_ctrl.sv @@
// ----------------------------------------------------------------------------
// stlb_ctrl
// Controller: sequences read and commit of each request and owns the
// stream handshakes and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_ctrl
	import stlb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_axis_tvalid,
	output      logic      s_axis_tready,
	output      logic      m_axis_tvalid,
	input  wire logic      m_axis_tready,
	output      stlb_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Decode commands
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && s_axis_tvalid;
		cmd.commit = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// hold the result until taken, refill on commit
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/stlb_dp.sv @@
// ----------------------------------------------------------------------------
// stlb_dp
// Datapath: per-way tag/page RAMs, valid flags, tag compare, victim choice,
// victim LFSR and the output result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_dp
	import stlb_pkg::*;
#(
	parameter int WAYS           = DEF_WAYS,
	parameter int SET_INDEX_BITS = DEF_SET_INDEX_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire stlb_cmd_t            cmd,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic [OP_W-1:0]      s_tuser,
	output      logic [M_TDATA_W-1:0] m_tdata,
	output      logic                 m_tuser
);

	localparam int SETS   = 1 << SET_INDEX_BITS;
	localparam int SET_W  = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TAG_W  = VA_W - OFF_W - SET_INDEX_BITS;
	localparam int ENT_W  = TAG_W + PPN_W;
	localparam int RCP_W  = 33;
	localparam int PROD_W = LFSR_W + RCP_W;
	localparam int QUO_W  = PROD_W - 32;
	localparam int REM_W  = QUO_W + 5;
	// floor(2^32 / WAYS): quotient estimate is short by at most one
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << 32) / WAYS);

	// Request registers
	op_t              op_q;
	logic [VA_W-1:0]  va_q;
	logic [PPN_W-1:0] ppn_q;
	logic [SET_W-1:0] in_set;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;

	// State
	logic [WAYS-1:0]   valid_q [SETS];
	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] lfsr_nxt;
	logic [PROD_W-1:0] prod_q;

	// Result register
	logic            hit_q;
	logic [PA_W-1:0] pa_q;

	// Way read data
	logic [ENT_W-1:0] rd_ent [WAYS];
	logic [WAYS-1:0]  row_valid;
	logic [WAYS-1:0]  hit_vec;
	logic [WAYS-1:0]  way_we;

	logic             hit_c;
	logic [PPN_W-1:0] ppn_sel;
	logic             found_c;
	logic [WAY_W-1:0] free_way;
	logic [QUO_W-1:0] quo_c;
	logic [REM_W-1:0] rem_c;
	logic [REM_W-1:0] rem_fix;
	logic [WAY_W-1:0] victim;
	logic             is_fill;

	// Set index of the incoming request
	if (SET_INDEX_BITS > 0) begin : g_set
		assign in_set = s_tdata[OFF_W +: SET_INDEX_BITS];
	end else begin : g_noset
		assign in_set = '0;
	end

	assign tag_q   = va_q[VA_W-1:OFF_W+SET_INDEX_BITS];
	assign is_fill = (op_q == OP_FILL);

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= s_tuser;
			va_q  <= s_tdata[VA_W-1:0];
			ppn_q <= s_tdata[VA_W +: PPN_W];
			set_q <= in_set;
		end
	end

	// One RAM per way, one row per set
	for (genvar w = 0; w < WAYS; w++) begin : g_way
		stlb_ram #(
			.WIDTH (ENT_W),
			.DEPTH (SETS),
			.ADDR_W(SET_W)
		) u_ram (
			.clk  (clk),
			.we   (way_we[w]),
			.waddr(set_q),
			.wdata({tag_q, ppn_q}),
			.re   (cmd.load),
			.raddr(in_set),
			.rdata(rd_ent[w])
		);
		assign way_we[w]  = cmd.commit && is_fill && (victim == WAY_W'(w));
		assign hit_vec[w] = row_valid[w] && (rd_ent[w][ENT_W-1:PPN_W] == tag_q);
	end

	assign row_valid = valid_q[set_q];

	// Lowest matching way wins
	always_comb begin
		ppn_sel = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				ppn_sel = rd_ent[w][PPN_W-1:0];
			end
		end
		hit_c = (op_q == OP_LOOKUP) && (|hit_vec);
	end

	// Highest invalid way
	always_comb begin
		found_c  = 1'b0;
		free_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!row_valid[w]) begin
				found_c  = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	// Victim: highest invalid way if any, else next LFSR value mod WAYS by reciprocal multiply
	assign lfsr_nxt = lfsr_step(lfsr_q);
	assign quo_c    = prod_q[PROD_W-1:32];
	assign rem_c    = REM_W'(lfsr_nxt) - REM_W'(quo_c * REM_W'(WAYS));
	assign rem_fix  = (rem_c >= REM_W'(WAYS)) ? (rem_c - REM_W'(WAYS)) : rem_c;
	assign victim   = found_c ? free_way : rem_fix[WAY_W-1:0];

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(lfsr_nxt) * PROD_W'(RECIP);
	end

	// Valid flags and LFSR
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
			end
			lfsr_q <= LFSR_SEED;
		end else if (cmd.commit) begin
			if (op_q == OP_FLUSH) begin
				for (int s = 0; s < SETS; s++) begin
					valid_q[s] <= '0;
				end
			end else if (is_fill) begin
				valid_q[set_q][victim] <= 1'b1;
				if (!found_c) begin
					lfsr_q <= lfsr_nxt;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q <= hit_c;
			pa_q  <= hit_c ? {ppn_sel, va_q[OFF_W-1:0]} : '0;
		end
	end

	assign m_tdata = M_TDATA_W'(pa_q);
	assign m_tuser = hit_q;

endmodule

`default_nettype wire

@@ design/set_associative_tlb.sv @@
// ----------------------------------------------------------------------------
// set_associative_tlb
// Set-associative TLB with lookup, fill and flush, random replacement.
//
//   channel   direction  tdata (low bit up)                 tuser
//   s_axis    in         virtual_address, fill_page_number  operation
//   m_axis    out        physical_address                   hit
//
// Each transaction has two steps: the set read from the way RAMs, then
// tag compare, victim choice and write-back.
// The input is taken again in the cycle after the commit.
// A result waits in the output register; the next transaction is accepted
// meanwhile, and its commit stalls only while that register is still full.
// Reset clears all valid flags at once and loads the LFSR seed.
// ----------------------------------------------------------------------------
`default_nettype none

module set_associative_tlb
	import stlb_pkg::*;
#(
	parameter int WAYS           = DEF_WAYS,
	parameter int SET_INDEX_BITS = DEF_SET_INDEX_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output      logic                 s_axis_tready,
	// virtual_address [47:0], fill_page_number [87:48]
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
	// operation [1:0]
	input  wire logic [OP_W-1:0]      s_axis_tuser,
	output      logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// physical_address [51:0], zero above
	output      logic [M_TDATA_W-1:0] m_axis_tdata,
	// hit [0]
	output      logic                 m_axis_tuser
);

	stlb_cmd_t cmd;

	// Sequence the transactions
	stlb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cmd          (cmd)
	);

	// Storage, compare and result
	stlb_dp #(
		.WAYS          (WAYS),
		.SET_INDEX_BITS(SET_INDEX_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.s_tdata(s_axis_tdata),
		.s_tuser(s_axis_tuser),
		.m_tdata(m_axis_tdata),
		.m_tuser(m_axis_tuser)
	);

endmodule

`default_nettype wire

@@ design/stlb_checker.sv @@
// ----------------------------------------------------------------------------
// stlb_checker
// Port-level checks of the TLB transaction flow and result coding.
// ----------------------------------------------------------------------------
`default_nettype none

module stlb_checker
	import stlb_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_axis_tvalid,
	input wire logic                 s_axis_tready,
	input wire logic                 m_axis_tvalid,
	input wire logic                 m_axis_tready,
	input wire logic [M_TDATA_W-1:0] m_axis_tdata,
	input wire logic                 m_axis_tuser
);

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// One transaction in flight: input closes after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("input accepted twice in a row");

	// A fresh result traces back to an accept, through the execute state and its commit
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_acc, 2))
		else $error("result without matching input transaction");

	// A miss or a non-lookup result carries a zero address
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("nonzero address without hit");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

endmodule

bind set_associative_tlb stlb_checker u_stlb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
